>>> hdl/detector_box_decode_unit_defines.svh
// Assertion macros shared by the detector box decode unit.
`ifndef DETECTOR_BOX_DECODE_UNIT_DEFINES_SVH
`define DETECTOR_BOX_DECODE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/dbd_pkg.sv
// Types and constants shared by the detector box decode unit.
package dbd_pkg;

    localparam int VALUE_BITS  = 24;
    localparam int MAX_CLASSES = 64;
    localparam int CLS_BITS    = 6;
    localparam int COORD_BITS  = 21;
    localparam int NUM_BITS    = 41;
    localparam int SCALE_BITS  = 24;
    localparam int MAX_SIDE    = 8192;

    localparam logic signed [VALUE_BITS-1:0] MINUS_ONE = -24'sd256;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_CLASSES   = 3'd1;
    localparam logic [2:0] REG_PAD_X     = 3'd2;
    localparam logic [2:0] REG_PAD_Y     = 3'd3;
    localparam logic [2:0] REG_SCALE     = 3'd4;
    localparam logic [2:0] REG_ORIG_W    = 3'd5;
    localparam logic [2:0] REG_ORIG_H    = 3'd6;
    localparam logic [2:0] REG_TOP1      = 3'd7;

    typedef struct packed {
        logic [22:0] min_score;
        logic [6:0]  class_count;
        logic [11:0] pad_x;
        logic [11:0] pad_y;
        logic [23:0] scale;
        logic [13:0] orig_w;
        logic [13:0] orig_h;
        logic        top1_only;
    } cfg_t;

    typedef struct packed {
        logic                         done;
        logic                         pass;
        logic                         eoi;
        logic signed [VALUE_BITS-1:0] cx;
        logic signed [VALUE_BITS-1:0] cy;
        logic signed [VALUE_BITS-1:0] w;
        logic signed [VALUE_BITS-1:0] h;
        logic signed [VALUE_BITS-1:0] score;
        logic [CLS_BITS-1:0]          cls;
    } job_t;

endpackage

>>> hdl/dbd_front.sv
// Front end: counts channels, keeps box values and the best class per anchor.
module dbd_front
    import dbd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         accept,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         end_of_image,
    output logic                         job_push,
    output job_t                         job
);

    logic [6:0]                   cnt_reg;
    logic signed [VALUE_BITS-1:0] box_reg [4];
    logic signed [VALUE_BITS-1:0] best_reg;
    logic [CLS_BITS-1:0]          idx_reg;

    logic [6:0]                   nc_eff;
    logic [6:0]                   pos_cls;
    logic                         better;
    logic                         done;
    logic                         pass;
    logic signed [VALUE_BITS-1:0] best_next;
    logic [CLS_BITS-1:0]          idx_next;

    always_comb
    begin
        if (cfg.class_count == 7'd0)
            nc_eff = 7'd1;
        else if (cfg.class_count > 7'(MAX_CLASSES))
            nc_eff = 7'(MAX_CLASSES);
        else
            nc_eff = cfg.class_count;
        pos_cls   = cnt_reg - 7'd4;
        better    = (cnt_reg >= 7'd4) && (value > best_reg);
        best_next = better ? value : best_reg;
        idx_next  = better ? pos_cls[CLS_BITS-1:0] : idx_reg;
        done      = cnt_reg >= (7'd3 + nc_eff);
        pass      = $signed({best_next[VALUE_BITS-1], best_next})
                    >= $signed({2'b00, cfg.min_score});
        job_push  = accept && (done || end_of_image);
        job.done  = done;
        job.pass  = pass;
        job.eoi   = end_of_image;
        job.cx    = box_reg[0];
        job.cy    = box_reg[1];
        job.w     = box_reg[2];
        job.h     = box_reg[3];
        job.score = best_next;
        job.cls   = idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 7'd0;
            best_reg <= MINUS_ONE;
            idx_reg  <= '0;
        end
        else if (accept)
        begin
            if (done || end_of_image)
            begin
                cnt_reg  <= 7'd0;
                best_reg <= MINUS_ONE;
                idx_reg  <= '0;
            end
            else
            begin
                cnt_reg  <= cnt_reg + 7'd1;
                best_reg <= best_next;
                idx_reg  <= idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (cnt_reg < 7'd4))
            box_reg[cnt_reg[1:0]] <= value;
    end

endmodule

>>> hdl/dbd_queue.sv
// Two-entry job queue between the front end and the back end.
module dbd_queue
    import dbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output job_t head
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> hdl/dbd_div.sv
// Restoring divider, one quotient bit per cycle.
module dbd_div
    import dbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NUM_BITS-1:0]   numer,
    input  logic [SCALE_BITS-1:0] denom,
    output logic                  done,
    output logic [NUM_BITS-1:0]   quot
);

    logic [SCALE_BITS:0]   rem_reg;
    logic [NUM_BITS-1:0]   quo_reg;
    logic [SCALE_BITS-1:0] den_reg;
    logic [5:0]            cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [SCALE_BITS:0]   trial;
    logic                  ge;

    always_comb
    begin
        trial = {rem_reg[SCALE_BITS-1:0], quo_reg[NUM_BITS-1]};
        ge    = trial >= {1'b0, den_reg};
    end

    assign done = done_reg;
    assign quot = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(NUM_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= numer;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial - {1'b0, den_reg} : trial;
            quo_reg <= {quo_reg[NUM_BITS-2:0], ge};
        end
    end

endmodule

>>> hdl/dbd_back.sv
// Back end: maps corners to the original image, keeps the top box, drives results.
module dbd_back
    import dbd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         job_valid,
    input  job_t                         job,
    output logic                         job_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic                         valid_res,
    output logic [COORD_BITS-1:0]        left,
    output logic [COORD_BITS-1:0]        top,
    output logic [COORD_BITS-1:0]        right,
    output logic [COORD_BITS-1:0]        bottom,
    output logic signed [VALUE_BITS-1:0] score,
    output logic [CLS_BITS-1:0]          class_id,
    output logic                         last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]                   state_reg;
    logic [1:0]                   k_reg;
    job_t                         job_reg;
    logic [COORD_BITS-1:0]        box_reg [4];
    logic [COORD_BITS-1:0]        tbox_reg [4];
    logic signed [VALUE_BITS-1:0] tscore_reg;
    logic [CLS_BITS-1:0]          tcls_reg;
    logic                         tvalid_reg;

    logic                         out_valid_reg;
    logic                         res_valid_reg;
    logic [COORD_BITS-1:0]        res_box_reg [4];
    logic signed [VALUE_BITS-1:0] res_score_reg;
    logic [CLS_BITS-1:0]          res_cls_reg;
    logic                         res_last_reg;

    logic                         o_valid_reg;
    logic [COORD_BITS-1:0]        o_box_reg [4];
    logic signed [VALUE_BITS-1:0] o_score_reg;
    logic [CLS_BITS-1:0]          o_cls_reg;
    logic                         o_last_reg;

    logic signed [VALUE_BITS-1:0] ca;
    logic signed [VALUE_BITS-1:0] cb;
    logic [11:0]                  pad;
    logic [13:0]                  side;
    logic [13:0]                  side_eff;
    logic [13:0]                  side_m1;
    logic [COORD_BITS-1:0]        hi;
    logic signed [26:0]           c9;
    logic signed [26:0]           m;
    logic                         m_pos;
    logic [NUM_BITS-1:0]          numer;
    logic [SCALE_BITS-1:0]        denom;
    logic                         div_start;
    logic                         div_done;
    logic [NUM_BITS-1:0]          quot;
    logic [COORD_BITS-1:0]        clamped;
    logic                         cand;
    logic                         take_top;
    logic                         emit;

    always_comb
    begin
        ca   = k_reg[0] ? job_reg.cy : job_reg.cx;
        cb   = k_reg[0] ? job_reg.h : job_reg.w;
        pad  = k_reg[0] ? cfg.pad_y : cfg.pad_x;
        side = k_reg[0] ? cfg.orig_h : cfg.orig_w;
        if (side == 14'd0)
            side_eff = 14'd1;
        else if (side > 14'(MAX_SIDE))
            side_eff = 14'(MAX_SIDE);
        else
            side_eff = side;
        side_m1 = side_eff - 14'd1;
        hi      = {side_m1[12:0], 8'd0};
        // Corners are formed at twice the resolution so that halving w or h is exact.
        if (k_reg[1])
            c9 = ($signed({{3{ca[VALUE_BITS-1]}}, ca}) <<< 1)
                 + $signed({{3{cb[VALUE_BITS-1]}}, cb});
        else
            c9 = ($signed({{3{ca[VALUE_BITS-1]}}, ca}) <<< 1)
                 - $signed({{3{cb[VALUE_BITS-1]}}, cb});
        m       = c9 - $signed({6'd0, pad, 9'd0});
        m_pos   = !m[26] && (m != 27'sd0);
        numer   = {m[25:0], 15'd0};
        denom   = (cfg.scale == 24'd0) ? 24'd1 : cfg.scale;
        clamped = (quot > NUM_BITS'(hi)) ? hi : quot[COORD_BITS-1:0];

        cand     = job_reg.done && job_reg.pass
                   && (box_reg[2] > box_reg[0]) && (box_reg[3] > box_reg[1]);
        take_top = cand && cfg.top1_only && (!tvalid_reg || (job_reg.score > tscore_reg));
        emit     = (cand && !cfg.top1_only) || job_reg.eoi;
        div_start = (state_reg == S_PREP) && m_pos;
        job_pop   = ((state_reg == S_EVAL) && !emit)
                    || ((state_reg == S_EMIT) && !out_valid_reg);
    end

    dbd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (numer),
        .denom (denom),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= 2'd0;
            tvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        k_reg     <= 2'd0;
                        state_reg <= (job.done && job.pass) ? S_PREP : S_EVAL;
                    end
                end
                S_PREP:
                begin
                    if (m_pos)
                        state_reg <= S_DIV;
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= (k_reg == 2'd3) ? S_EVAL : S_PREP;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= (k_reg == 2'd3) ? S_EVAL : S_PREP;
                    end
                end
                S_EVAL:
                begin
                    if (take_top)
                        tvalid_reg <= 1'b1;
                    if (job_reg.eoi)
                        tvalid_reg <= 1'b0;
                    state_reg <= emit ? S_EMIT : S_IDLE;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && job_valid)
            job_reg <= job;
        if (state_reg == S_PREP && !m_pos)
            box_reg[k_reg] <= '0;
        if (state_reg == S_DIV && div_done)
            box_reg[k_reg] <= clamped;
        if (state_reg == S_EVAL)
        begin
            if (take_top)
            begin
                tbox_reg   <= box_reg;
                tscore_reg <= job_reg.score;
                tcls_reg   <= job_reg.cls;
            end
            res_last_reg <= job_reg.eoi;
            if (cand && !cfg.top1_only)
            begin
                res_valid_reg <= 1'b1;
                res_box_reg   <= box_reg;
                res_score_reg <= job_reg.score;
                res_cls_reg   <= job_reg.cls;
            end
            else if (cfg.top1_only && take_top)
            begin
                res_valid_reg <= 1'b1;
                res_box_reg   <= box_reg;
                res_score_reg <= job_reg.score;
                res_cls_reg   <= job_reg.cls;
            end
            else if (cfg.top1_only && tvalid_reg)
            begin
                res_valid_reg <= 1'b1;
                res_box_reg   <= tbox_reg;
                res_score_reg <= tscore_reg;
                res_cls_reg   <= tcls_reg;
            end
            else
            begin
                res_valid_reg <= 1'b0;
                res_box_reg   <= '{default: '0};
                res_score_reg <= '0;
                res_cls_reg   <= '0;
            end
        end
        if (state_reg == S_EMIT && !out_valid_reg)
        begin
            o_valid_reg <= res_valid_reg;
            o_box_reg   <= res_box_reg;
            o_score_reg <= res_score_reg;
            o_cls_reg   <= res_cls_reg;
            o_last_reg  <= res_last_reg;
        end
    end

    assign empty     = !out_valid_reg;
    assign valid_res = o_valid_reg;
    assign left      = o_box_reg[0];
    assign top       = o_box_reg[1];
    assign right     = o_box_reg[2];
    assign bottom    = o_box_reg[3];
    assign score     = o_score_reg;
    assign class_id  = o_cls_reg;
    assign last      = o_last_reg;

endmodule

>>> hdl/detector_box_decode_unit.sv
// Top level of the detector box decode unit: register port, front, queue and back.
//
//  Channel   Direction  Handshake          Payload
//  input     in         push / full        value, end_of_image
//  result    out        pop / empty        valid_res, left, top, right, bottom,
//                                          score, class_id, last
//  config    in         psel / penable     paddr, pwdata, prdata
//
// A tensor value is taken every cycle while the two-entry job queue has room.
// Each surviving anchor holds the back end while its corners are divided: the
// one-bit-per-cycle divider is shared by the four corners, which take turns;
// a dropped anchor skips the divider, and is also emitted when it closes an image.
// Results wait in one output register until popped.
// Reset clears the anchor counter, the top-box flag and the queue, sets the best
// score to MINUS_ONE; configuration registers return to their reset values.
`include "detector_box_decode_unit_defines.svh"

module detector_box_decode_unit
    import dbd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         end_of_image,
    input  logic                         pop,
    output logic                         empty,
    output logic                         valid_res,
    output logic [COORD_BITS-1:0]        left,
    output logic [COORD_BITS-1:0]        top,
    output logic [COORD_BITS-1:0]        right,
    output logic [COORD_BITS-1:0]        bottom,
    output logic signed [VALUE_BITS-1:0] score,
    output logic [CLS_BITS-1:0]          class_id,
    output logic                         last
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic       accept;
    logic       job_push;
    job_t       job_in;
    logic       q_not_empty;
    job_t       q_head;
    logic       q_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign accept  = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_score   <= 23'd64;
            cfg_reg.class_count <= 7'd2;
            cfg_reg.pad_x       <= 12'd0;
            cfg_reg.pad_y       <= 12'd0;
            cfg_reg.scale       <= 24'd65536;
            cfg_reg.orig_w      <= 14'd640;
            cfg_reg.orig_h      <= 14'd640;
            cfg_reg.top1_only   <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_THRESHOLD: cfg_reg.min_score   <= pwdata[22:0];
                REG_CLASSES:   cfg_reg.class_count <= pwdata[6:0];
                REG_PAD_X:     cfg_reg.pad_x       <= pwdata[11:0];
                REG_PAD_Y:     cfg_reg.pad_y       <= pwdata[11:0];
                REG_SCALE:     cfg_reg.scale       <= pwdata[23:0];
                REG_ORIG_W:    cfg_reg.orig_w      <= pwdata[13:0];
                REG_ORIG_H:    cfg_reg.orig_h      <= pwdata[13:0];
                REG_TOP1:      cfg_reg.top1_only   <= pwdata[0];
                default:       cfg_reg.top1_only   <= cfg_reg.top1_only;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_THRESHOLD: prdata = {9'd0, cfg_reg.min_score};
            REG_CLASSES:   prdata = {25'd0, cfg_reg.class_count};
            REG_PAD_X:     prdata = {20'd0, cfg_reg.pad_x};
            REG_PAD_Y:     prdata = {20'd0, cfg_reg.pad_y};
            REG_SCALE:     prdata = {8'd0, cfg_reg.scale};
            REG_ORIG_W:    prdata = {18'd0, cfg_reg.orig_w};
            REG_ORIG_H:    prdata = {18'd0, cfg_reg.orig_h};
            REG_TOP1:      prdata = {31'd0, cfg_reg.top1_only};
            default:       prdata = 32'd0;
        endcase
    end

    dbd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .value        (value),
        .end_of_image (end_of_image),
        .job_push     (job_push),
        .job          (job_in)
    );

    dbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (q_pop),
        .full      (full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    dbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (q_not_empty),
        .job       (q_head),
        .job_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .valid_res (valid_res),
        .left      (left),
        .top       (top),
        .right     (right),
        .bottom    (bottom),
        .score     (score),
        .class_id  (class_id),
        .last      (last)
    );

    // An empty result is only ever the closing transfer of an image.
    `DBD_ASSERT_SAME(a_empty_is_last, !empty && !valid_res, last, "empty result without last")
    // Fields of an empty result read as zero.
    `DBD_ASSERT_SAME(a_empty_zero, !empty && !valid_res,
        left == 21'd0 && right == 21'd0 && score == 24'sd0 && class_id == 6'd0,
        "empty result with nonzero fields")
    // A waiting result is never dropped before it is taken.
    `DBD_ASSERT_NEXT(a_result_held, !empty && !pop, !empty, "result lost while waiting")
    // The back end only retires a job that the queue holds.
    `DBD_ASSERT_SAME(a_pop_has_job, q_pop, q_not_empty, "job retired from empty queue")

endmodule
